// ===== hw/rtl/aes_pkg.sv =====
package aes_pkg;

   localparam int BlockWidth = 128;
   localparam int WordWidth = 64;
   localparam int NumRounds = 14;
   localparam int NumRoundKeys = 15;
   localparam int RoundIdxWidth = 4;
   localparam int KeyStepWidth = 6;
   localparam int NumKeySteps = 52;
   localparam int CsrIdxWidth = 3;

   localparam logic [CsrIdxWidth-1:0] CSR_KEY_0 = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_1 = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_2 = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_3 = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_IV_HIGH = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_IV_LOW = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_DIRECTION = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CSR_CHAINING = 3'd7;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                     key_init;
      logic                     key_step;
      logic [KeyStepWidth-1:0]  key_idx;
      logic                     load;
      logic                     round;
      logic [RoundIdxWidth-1:0] round_idx;
      logic                     finish;
   } dp_cmd_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[a];
   endfunction

endpackage

// ===== hw/rtl/aes_ram.sv =====
module aes_ram #(
   parameter int Width = 64,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/aes_datapath.sv =====
module aes_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  aes_pkg::dp_cmd_type   cmd,
   input  logic [255:0]          key,
   input  logic [127:0]          iv,
   input  logic                  decrypt,
   input  logic                  cbc,
   input  logic [127:0]          in_block,
   input  logic                  in_new_msg,
   output logic [127:0]          out_block
);
   import aes_pkg::*;

   // Key schedule: a window of the last eight words slides one word a step.
   logic [255:0] kwin_ff, kwin_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] state_ff, state_in;
   logic [127:0] in_ff;
   logic [127:0] out_ff;
   logic [RoundIdxWidth-1:0] ridx_ff;
   logic         wr_en;
   logic [RoundIdxWidth-1:0] wr_addr;
   logic [127:0] rk;
   logic [31:0]  t, nw;
   logic [2:0]   step_mod;

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] mixcol(input logic [31:0] c, input logic inv);
      logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, u, v;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      if (inv) begin
         // Pre-step turns InvMixColumns into MixColumns.
         u = xt(xt(a0 ^ a2));
         v = xt(xt(a1 ^ a3));
         a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
      end
      x0 = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      x1 = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      x2 = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      x3 = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      return {x0, x1, x2, x3};
   endfunction

   // Byte k of the block sits at bits 127-8k.
   function automatic logic [7:0] bget(input logic [127:0] s, input int k);
      return s[127-8*k -: 8];
   endfunction

   function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic last);
      logic [127:0] o;
      logic [127:0] m;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[127-8*(c*4+r) -: 8] = sbox(bget(s, ((c + r) % 4) * 4 + r));
         end
      end
      for (int c = 0; c < 4; c++) begin
         m[127-32*c -: 32] = mixcol(o[127-32*c -: 32], 1'b0);
      end
      return last ? o : m;
   endfunction

   function automatic logic [127:0] inv_round(input logic [127:0] s, input logic first);
      logic [127:0] m;
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         m[127-32*c -: 32] = mixcol(s[127-32*c -: 32], 1'b1);
      end
      if (first) begin
         m = s;
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[127-8*(((c + r) % 4) * 4 + r) -: 8] = inv_sbox(bget(m, c*4+r));
         end
      end
      return o;
   endfunction

   // Next key word from the window.
   always_comb begin
      step_mod = cmd.key_idx[2:0];
      t = kwin_ff[31:0];
      if (step_mod == 3'd0) begin
         t = {sbox(t[23:16]) ^ rcon_ff, sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])};
      end else if (step_mod == 3'd4) begin
         t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
      end
      nw = kwin_ff[255:224] ^ t;
      kwin_in = kwin_ff;
      rcon_in = rcon_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      if (cmd.key_init) begin
         kwin_in = key;
         rcon_in = 8'h01;
         wr_en = 1'b1;
         wr_addr = '0;
      end else if (cmd.key_step) begin
         kwin_in = {kwin_ff[223:0], nw};
         if (step_mod == 3'd0) begin
            rcon_in = xt(rcon_ff);
         end
         // A full round key is ready after every fourth word.
         if (cmd.key_idx[1:0] == 2'd3) begin
            wr_en = 1'b1;
            wr_addr = RoundIdxWidth'((cmd.key_idx - KeyStepWidth'(8)) / 4 + 2);
         end
      end
   end

   logic [127:0] wr_data;
   assign wr_data = cmd.key_init ? key[255:128] : kwin_in[127:0];

   // Round key memory: one 128-bit key per round, addressed in the cycle before the key is used.
   aes_ram #(.Width(BlockWidth), .Depth(16)) u_rk_ram (
      .clock   (clock),
      .wr_en   (wr_en || (cmd.key_step && cmd.key_idx == KeyStepWidth'(8))),
      .wr_addr ((cmd.key_step && cmd.key_idx == KeyStepWidth'(8)) ? RoundIdxWidth'(1)
                                                                 : wr_addr),
      .wr_data ((cmd.key_step && cmd.key_idx == KeyStepWidth'(8)) ? kwin_ff[127:0]
                                                                 : wr_data),
      .rd_addr (cmd.round_idx),
      .rd_data (rk)
   );

   // Block state and chain. The round number matches the key read last cycle.
   // Decrypt applies InvMixColumns at the start of each round after the first.
   logic [127:0] chain_use;
   always_comb begin
      chain_use = in_new_msg ? iv : chain_ff;
      state_in = state_ff;
      chain_in = chain_ff;
      if (cmd.load) begin
         state_in = (cbc && !decrypt) ? in_block ^ chain_use : in_block;
         chain_in = chain_use;
      end else if (cmd.round) begin
         if (decrypt) begin
            if (ridx_ff == RoundIdxWidth'(NumRounds)) begin
               state_in = state_ff ^ rk;
            end else begin
               state_in = inv_round(state_ff, ridx_ff == RoundIdxWidth'(NumRounds - 1)) ^ rk;
            end
         end else begin
            if (ridx_ff == '0) begin
               state_in = state_ff ^ rk;
            end else begin
               state_in = fwd_round(state_ff, ridx_ff == RoundIdxWidth'(NumRounds)) ^ rk;
            end
         end
      end else if (cmd.finish && cbc) begin
         chain_in = decrypt ? in_ff : state_ff;
      end
   end

   // Registers; only the chain value needs a defined reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else begin
         chain_ff <= chain_in;
      end
      kwin_ff <= kwin_in;
      rcon_ff <= rcon_in;
      state_ff <= state_in;
      ridx_ff <= cmd.round_idx;
      if (cmd.load) begin
         in_ff <= in_block;
      end
      if (cmd.finish) begin
         out_ff <= (decrypt && cbc) ? state_ff ^ chain_ff : state_ff;
      end
   end

   assign out_block = out_ff;

endmodule

// ===== hw/rtl/aes_control.sv =====
module aes_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                keys_ready,
   input  logic                decrypt,
   input  logic                req_fire,
   input  logic                rsp_free,
   output logic                busy,
   output logic                key_done,
   output logic                rsp_load,
   output aes_pkg::dp_cmd_type cmd
);
   import aes_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_KEY    = 5'b00010,
      ST_ROUND  = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_HOLD   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [KeyStepWidth-1:0]  kidx_ff, kidx_in;
   logic [RoundIdxWidth-1:0] rnd_ff, rnd_in;
   logic                     started_ff, started_in;

   always_comb begin
      state_in = state_ff;
      kidx_in = kidx_ff;
      rnd_in = rnd_ff;
      started_in = started_ff;
      cmd = '0;
      busy = 1'b1;
      key_done = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (req_fire) begin
               cmd.load = 1'b1;
               if (!keys_ready) begin
                  cmd.key_init = 1'b1;
                  kidx_in = KeyStepWidth'(8);
                  state_in = ST_KEY;
               end else begin
                  state_in = ST_ROUND;
               end
               rnd_in = decrypt ? RoundIdxWidth'(NumRounds) : '0;
               cmd.round_idx = rnd_in;
               started_in = 1'b0;
            end
         end
         ST_KEY: begin
            cmd.key_step = 1'b1;
            cmd.key_idx = kidx_ff;
            kidx_in = kidx_ff + 1'b1;
            if (kidx_ff == KeyStepWidth'(NumKeySteps + 7)) begin
               key_done = 1'b1;
               state_in = ST_ROUND;
            end
            // Address the first round key during every key step.
            cmd.round_idx = rnd_ff;
         end
         ST_ROUND: begin
            cmd.round_idx = rnd_ff;
            if (!started_ff) begin
               // Wait for the registered key read.
               started_in = 1'b1;
            end else begin
               cmd.round = 1'b1;
               if (decrypt) begin
                  rnd_in = rnd_ff - 1'b1;
               end else begin
                  rnd_in = rnd_ff + 1'b1;
               end
               cmd.round_idx = rnd_in;
               if ((decrypt && rnd_ff == '0) ||
                   (!decrypt && rnd_ff == RoundIdxWidth'(NumRounds))) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kidx_ff <= '0;
         rnd_ff <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kidx_ff <= kidx_in;
         rnd_ff <= rnd_in;
         started_ff <= started_in;
      end
   end

endmodule

// ===== hw/rtl/aes256_block_cipher_ecb_cbc_unit.sv =====
// Channel  | Direction | Payload
// ---------+-----------+--------------------------------------------------
// req_     | in        | tdata = block_high [63:0], block_low [127:64]; tuser = new_message
// rsp_     | out       | tdata = out_high [63:0], out_low [127:64]
// csr_     | in        | index (3 bits), data (64 bits)
// A block holds the core between acceptances: the accepting cycle loads it, a wait
// for the registered key read, the round steps (key addition and 14 rounds), a
// finish step and a hand-off to the response register.
// After a key write the first block also runs the key schedule, one word per
// cycle, before its rounds. Reset is synchronous and active high; one waiting
// response lets the next block run, a second one stalls the core at its hand-off.
module aes256_block_cipher_ecb_cbc_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // block_high, block_low
   input  logic         req_tuser,   // new_message
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // out_high, out_low
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [aes_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [63:0]  csr_data
);
   import aes_pkg::*;

   logic [255:0] key_ff;
   logic [127:0] iv_ff;
   logic         dir_ff, cbc_ff, kready_ff;
   logic         rsp_valid_ff;
   logic [127:0] rsp_data_ff;
   logic [127:0] in_block, out_block;
   logic         busy, key_done, rsp_load, req_fire;
   dp_cmd_type   cmd;

   assign csr_ready = 1'b1;
   assign req_tready = !busy;
   assign req_fire = req_tvalid && req_tready;
   assign in_block = {req_tdata[63:0], req_tdata[127:64]};

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         iv_ff <= '0;
         dir_ff <= 1'b0;
         cbc_ff <= 1'b0;
         kready_ff <= 1'b0;
      end else begin
         if (key_done) begin
            kready_ff <= 1'b1;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_KEY_0: begin key_ff[255:192] <= csr_data; kready_ff <= 1'b0; end
               CSR_KEY_1: begin key_ff[191:128] <= csr_data; kready_ff <= 1'b0; end
               CSR_KEY_2: begin key_ff[127:64] <= csr_data; kready_ff <= 1'b0; end
               CSR_KEY_3: begin key_ff[63:0] <= csr_data; kready_ff <= 1'b0; end
               CSR_IV_HIGH: iv_ff[127:64] <= csr_data;
               CSR_IV_LOW: iv_ff[63:0] <= csr_data;
               CSR_DIRECTION: dir_ff <= csr_data[0];
               CSR_CHAINING: cbc_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   aes_control u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .keys_ready (kready_ff),
      .decrypt    (dir_ff),
      .req_fire   (req_fire),
      .rsp_free   (!rsp_valid_ff || rsp_tready),
      .busy       (busy),
      .key_done   (key_done),
      .rsp_load   (rsp_load),
      .cmd        (cmd)
   );

   aes_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .key        (key_ff),
      .iv         (iv_ff),
      .decrypt    (dir_ff),
      .cbc        (cbc_ff),
      .in_block   (in_block),
      .in_new_msg (req_tuser),
      .out_block  (out_block)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff <= out_block;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_data_ff[63:0], rsp_data_ff[127:64]};

endmodule

// ===== bench/aes256_block_cipher_ecb_cbc_unit_tb.sv =====
`timescale 1ns / 100ps

module aes256_block_cipher_ecb_cbc_unit_tb;
   import aes_pkg::*;

   typedef struct {
      logic [63:0] blk_high;
      logic [63:0] blk_low;
      logic        new_msg;
   } block_req_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;    // block_high, block_low
   logic         req_tuser = 1'b0;  // new_message
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;         // out_high, out_low
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [63:0]  csr_data = '0;

   aes256_block_cipher_ecb_cbc_unit DUT (.*);

   always #5 clock = ~clock;

   // Cipher tables, derived from the field inverse and the affine map.
   logic [7:0]   fwd_tab [256];
   logic [7:0]   rev_tab [256];

   // Mirror of the block's registers and chaining state.
   logic [63:0]  key_words [4] = '{default: '0};
   logic [63:0]  iv_words [2] = '{default: '0};
   logic         decrypt_mode = 1'b0;
   logic         cbc_mode = 1'b0;
   logic [63:0]  round_keys [30];
   logic [63:0]  chain_words [2] = '{default: '0};
   logic         schedule_valid = 1'b0;

   block_req_type pending_blocks [$];
   logic [127:0] expected_blocks [$];
   int           mismatch_count = 0;
   int           accepted_count = 0;
   int           hold_left = 0;
   logic         hold_done = 1'b0;
   logic         quiet = 1'b0;
   logic         req_took = 1'b0;
   logic         csr_took = 1'b0;

   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [7:0] rotl8(logic [7:0] b, int n);
      logic [15:0] d;
      d = {b, b} << n;
      return d[15:8];
   endfunction

   function automatic logic [7:0] byte_at(logic [127:0] s, int k);
      return s[127-8*k -: 8];
   endfunction

   function automatic logic [127:0] stage_key(int r);
      return {round_keys[2*r], round_keys[2*r+1]};
   endfunction

   function automatic logic [127:0] sub_bytes(logic [127:0] s, logic inverse);
      logic [127:0] o;
      for (int k = 0; k < 16; k++)
         o[127-8*k -: 8] = inverse ? rev_tab[byte_at(s, k)] : fwd_tab[byte_at(s, k)];
      return o;
   endfunction

   // Byte (column c, row r) sits at index 4c+r.
   function automatic logic [127:0] shift_rows(logic [127:0] s, logic inverse);
      logic [127:0] o;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            if (inverse) o[127-8*(((c+r)&3)*4+r) -: 8] = byte_at(s, c*4+r);
            else o[127-8*(c*4+r) -: 8] = byte_at(s, ((c+r)&3)*4+r);
         end
      return o;
   endfunction

   function automatic logic [127:0] mix_columns(logic [127:0] s, logic inverse);
      logic [127:0] o;
      logic [7:0]   m [4];
      logic [7:0]   a [4];
      if (inverse) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else m = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) a[i] = byte_at(s, c*4+i);
         for (int r = 0; r < 4; r++)
            o[127-8*(c*4+r) -: 8] = gf_mul(m[(4-r)&3], a[0]) ^ gf_mul(m[(5-r)&3], a[1]) ^
                                    gf_mul(m[(6-r)&3], a[2]) ^ gf_mul(m[(7-r)&3], a[3]);
      end
      return o;
   endfunction

   function automatic logic [127:0] cipher_forward(logic [127:0] s);
      s ^= stage_key(0);
      for (int r = 1; r <= NumRounds; r++) begin
         s = shift_rows(sub_bytes(s, 1'b0), 1'b0);
         if (r < NumRounds) s = mix_columns(s, 1'b0);
         s ^= stage_key(r);
      end
      return s;
   endfunction

   function automatic logic [127:0] cipher_inverse(logic [127:0] s);
      s ^= stage_key(NumRounds);
      for (int r = NumRounds - 1; r >= 0; r--) begin
         s = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ stage_key(r);
         if (r > 0) s = mix_columns(s, 1'b1);
      end
      return s;
   endfunction

   // 256-bit key schedule into sixty 32-bit words, stored as thirty pairs.
   task automatic expand_key_schedule();
      logic [255:0] k;
      logic [31:0]  w [60];
      logic [31:0]  t;
      logic [7:0]   rcon;
      k = {key_words[0], key_words[1], key_words[2], key_words[3]};
      rcon = 8'h01;
      for (int i = 0; i < 8; i++) w[i] = k[255-32*i -: 32];
      for (int i = 8; i < 60; i++) begin
         t = w[i-1];
         if ((i & 7) == 0) begin
            t = {t[23:0], t[31:24]};
            t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
            t[31:24] ^= rcon;
            rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
         end else if ((i & 7) == 4) begin
            t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
         end
         w[i] = w[i-8] ^ t;
      end
      for (int i = 0; i < 30; i++) round_keys[i] = {w[2*i], w[2*i+1]};
      schedule_valid = 1'b1;
   endtask

   task automatic apply_register_write(logic [CsrIdxWidth-1:0] idx, logic [63:0] d);
      case (idx)
         CSR_KEY_0, CSR_KEY_1, CSR_KEY_2, CSR_KEY_3: begin
            key_words[idx] = d;
            schedule_valid = 1'b0;
         end
         CSR_IV_HIGH: iv_words[0] = d;
         CSR_IV_LOW: iv_words[1] = d;
         CSR_DIRECTION: decrypt_mode = d[0];
         CSR_CHAINING: cbc_mode = d[0];
         default: ;
      endcase
   endtask

   task automatic predict_cipher_result(block_req_type b, output logic [127:0] res);
      logic [127:0] chain;
      if (!schedule_valid) expand_key_schedule();
      if (b.new_msg) chain_words = iv_words;
      chain = {chain_words[0], chain_words[1]};
      if (!decrypt_mode) begin
         res = cipher_forward({b.blk_high, b.blk_low} ^ (cbc_mode ? chain : 128'd0));
         if (cbc_mode) chain_words = '{res[127:64], res[63:0]};
      end else begin
         res = cipher_inverse({b.blk_high, b.blk_low}) ^ (cbc_mode ? chain : 128'd0);
         if (cbc_mode) chain_words = '{b.blk_high, b.blk_low};
      end
   endtask

   task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%s wrong: expected %h, got %h", field, want, got);
      end
   endtask

   // Build the cipher tables once.
   initial begin
      logic [7:0] inv, s;
      for (int x = 0; x < 256; x++) begin
         inv = '0;
         for (int y = 1; y < 256; y++)
            if (x != 0 && gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         s = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
         fwd_tab[x] = s;
         rev_tab[s] = x[7:0];
      end
   end

   // Sample both handshakes and the result channel.
   always @(posedge clock) begin
      block_req_type b;
      logic [127:0] want;
      req_took <= req_tvalid && req_tready;
      csr_took <= csr_valid && csr_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_register_write(csr_index, csr_data);
         if (req_tvalid && req_tready) begin
            b.blk_high = req_tdata[63:0];
            b.blk_low = req_tdata[127:64];
            b.new_msg = req_tuser;
            predict_cipher_result(b, want);
            expected_blocks = {expected_blocks, want};
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("result with no request outstanding");
            end else begin
               want = expected_blocks.pop_front();
               report_field("out_high", want[127:64], rsp_tdata[63:0]);
               report_field("out_low", want[63:0], rsp_tdata[127:64]);
            end
         end
      end
   end

   // Long receiver hold-off once, so the block backs up and stalls its input.
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      else if (!hold_done && accepted_count >= 600) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end
   end

   // Request driver.
   always @(negedge clock) begin
      block_req_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (pending_blocks.size() > 0 && (quiet || $urandom_range(99) >= 34)) begin
            b = pending_blocks.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {b.blk_low, b.blk_high};
            req_tuser <= b.new_msg;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response acceptor.
   always @(negedge clock) begin
      rsp_tready <= !reset && hold_left == 0 && (quiet || $urandom_range(99) >= 34);
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_word();
      case ($urandom_range(3))
         0: return 64'd0;
         1: return '1;
         default: return rand_word();
      endcase
   endfunction

   task automatic queue_block(logic [63:0] h, logic [63:0] l, logic nm);
      block_req_type b;
      b.blk_high = h;
      b.blk_low = l;
      b.new_msg = nm;
      pending_blocks = {pending_blocks, b};
   endtask

   task automatic csr_write(logic [CsrIdxWidth-1:0] idx, logic [63:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(negedge clock); while (!csr_took);
      csr_valid <= 1'b0;
   endtask

   // Let all queued requests finish, then give the block time to settle.
   task automatic drain();
      do @(negedge clock);
      while (pending_blocks.size() > 0 || req_tvalid || expected_blocks.size() > 0);
      repeat (80) @(negedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero key, ECB encrypt, field extremes.
      queue_block('0, '0, 1'b0);
      queue_block('1, '1, 1'b0);
      queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
      drain();

      // CBC with no new message yet, so the chain starts at zero.
      csr_write(CSR_CHAINING, 64'd1);
      queue_block(rand_word(), rand_word(), 1'b0);
      queue_block(rand_word(), rand_word(), 1'b0);
      drain();

      // An IV write is held until a block marks a new message.
      csr_write(CSR_IV_HIGH, '1);
      csr_write(CSR_IV_LOW, '1);
      queue_block(rand_word(), rand_word(), 1'b0);
      queue_block(rand_word(), rand_word(), 1'b1);
      queue_block(rand_word(), rand_word(), 1'b0);
      drain();

      // Switching to decrypt in the middle of a message keeps the chain.
      csr_write(CSR_DIRECTION, 64'd1);
      queue_block(rand_word(), rand_word(), 1'b0);
      queue_block(rand_word(), rand_word(), 1'b1);
      queue_block('1, '0, 1'b0);
      drain();

      // ECB with new-message marks; upper register bits must be ignored.
      csr_write(CSR_CHAINING, 64'hffff_ffff_ffff_fffe);
      queue_block(rand_word(), rand_word(), 1'b1);
      queue_block('0, '1, 1'b1);
      drain();

      // New all-ones key: the next block runs the key schedule first.
      csr_write(CSR_KEY_0, '1);
      csr_write(CSR_KEY_1, '1);
      csr_write(CSR_KEY_2, '1);
      csr_write(CSR_KEY_3, '1);
      queue_block('0, '0, 1'b0);
      queue_block('1, '1, 1'b1);
      drain();
      csr_write(CSR_DIRECTION, 64'hffff_ffff_ffff_fffe);
      queue_block('1, '1, 1'b0);
      drain();

      // Random phases with fresh settings between them.
      for (int p = 0; p < 16; p++) begin
         quiet = (p == 5);
         for (int idx = 0; idx < 8; idx++)
            if ($urandom_range(1)) begin
               if (idx >= CSR_DIRECTION) csr_write(idx[CsrIdxWidth-1:0], rand_word());
               else csr_write(idx[CsrIdxWidth-1:0], pick_word());
            end
         for (int i = 0; i < 100; i++)
            queue_block(rand_word(), rand_word(),
                        (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(9) == 0));
         drain();
      end
      quiet = 1'b0;

      if (mismatch_count == 0) begin
         $display("aes256_block_cipher_ecb_cbc_unit: match");
      end else begin
         $display("aes256_block_cipher_ecb_cbc_unit: mismatch");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #20_000_000;
      $display("aes256_block_cipher_ecb_cbc_unit: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/aes_pkg.sv
hw/rtl/aes_ram.sv
hw/rtl/aes_datapath.sv
hw/rtl/aes_control.sv
hw/rtl/aes256_block_cipher_ecb_cbc_unit.sv
bench/aes256_block_cipher_ecb_cbc_unit_tb.sv
